@@ rtl/gob_pkg.sv @@
// package for the gradient orientation binner: widths, constants and item types
// used by gob_scale, gob_isqrt and gradient_orientation_binner; no dependencies
`timescale 1ns / 1ps

package gob_pkg;

  localparam int PIXEL_BITS     = 24;
  localparam int GRAD_FRAC_BITS = 16;
  localparam int PIX_FRAC       = 4;
  localparam int SPREAD_FRAC    = 32;
  localparam int SPREAD_BITS    = 40;

  // product of difference and inverse spread is taken down to the gradient format
  localparam int SCALE_SHIFT   = PIX_FRAC + SPREAD_FRAC - GRAD_FRAC_BITS;
  localparam int INV_HI_BITS   = SPREAD_BITS - SCALE_SHIFT;
  localparam int PROD_HI_BITS  = PIXEL_BITS + INV_HI_BITS;
  localparam int PROD_LO_BITS  = PIXEL_BITS + SCALE_SHIFT;
  localparam int SUM_BITS      = ((PROD_HI_BITS > PROD_LO_BITS - SCALE_SHIFT) ?
                                  PROD_HI_BITS : PROD_LO_BITS - SCALE_SHIFT) + 1;

  localparam int GRAD_BITS = 32;
  localparam int MAG_BITS  = GRAD_BITS - 1;
  localparam logic [MAG_BITS-1:0] GRAD_MAX = '1;

  // 0.0001 rounded to nearest at the gradient fraction
  localparam int DX_BIAS = ((1 << GRAD_FRAC_BITS) + 5000) / 10000;

  // tan 22.5 and tan 67.5 with 30 fraction bits
  localparam int TAN_FRAC = 30;
  localparam logic [31:0] TAN22_Q30 = 32'd444758426;
  localparam logic [31:0] TAN67_Q30 = 32'd2592242074;
  localparam int EDGE_BITS = 32 + MAG_BITS;
  localparam int CMP_BITS  = GRAD_BITS + TAN_FRAC + 3;

  localparam int BIN_BITS = 3;
  localparam logic [BIN_BITS-1:0] BIN_OFFSET   = 3'd4;
  localparam logic [BIN_BITS-1:0] BIN_VERTICAL = 3'd4;
  localparam logic [BIN_BITS-1:0] BIN_BORDER   = 3'd0;

  localparam int SQ_BITS     = 2 * MAG_BITS + 1;
  localparam int RAD_BITS    = 64;
  localparam int ROOT_BITS   = 32;
  localparam int REM_BITS    = ROOT_BITS + 4;
  localparam int SQRT_STAGES = RAD_BITS / 2;

  localparam int SCALE_LAT = 3;
  localparam int PIPE_LAT  = SCALE_LAT + 4 + SQRT_STAGES;

  localparam logic [SPREAD_BITS-1:0] INV_SPREAD_RESET = SPREAD_BITS'(64'd1 << SPREAD_FRAC);

  typedef logic [BIN_BITS-1:0] bin_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel_above;
    logic [PIXEL_BITS-1:0] pixel_below;
    logic [PIXEL_BITS-1:0] pixel_left;
    logic [PIXEL_BITS-1:0] pixel_right;
    logic                  on_border;
  } pixel_item_t;

  typedef struct packed {
    bin_t                 orientation_bin;
    logic [ROOT_BITS-1:0] gradient_magnitude;
  } result_item_t;

  typedef struct packed {
    logic [RAD_BITS-1:0] radicand;
    bin_t                bin;
  } sqrt_in_t;

endpackage

@@ rtl/gradient_orientation_binner.sv @@
// gradient orientation binner top level: central differences, 8-bin orientation
// and magnitude; depends on gob_pkg, gob_scale and gob_isqrt
`timescale 1ns / 1ps

// One pixel item enters per clock and its result leaves the pipeline as a
// one-cycle strobe on result_valid. The pipeline is fully stalled-free: three
// stages scale the differences, four form the signed gradient, the thresholds
// and the sum of squares, and a 32-stage square root, one result bit per stage,
// sets most of the latency. busy is high only while reset is held; results
// cannot be held off and must be taken the cycle they appear. inverse_spread
// is written through cfg_wr_en/cfg_wr_data and should change only when no items
// are in flight.

module gradient_orientation_binner import gob_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  pixel_item_t            pixels,
  input  logic                   cfg_wr_en,
  input  logic [SPREAD_BITS-1:0] cfg_wr_data,
  output logic                   result_valid,
  output result_item_t           result
);

  logic [SPREAD_BITS-1:0] inv_spread;
  logic [PIPE_LAT-1:0]    vld;
  logic [SCALE_LAT-1:0]   brd_d;

  logic [MAG_BITS-1:0] mag_x, mag_y;
  logic                neg_x, neg_y;

  // gradient stage
  logic signed [GRAD_BITS:0]   dx_wide;
  logic signed [GRAD_BITS-1:0] dx4, dy4;
  logic                        brd4;

  // fold stage
  logic [MAG_BITS-1:0]           ax5;
  logic signed [GRAD_BITS-1:0]   ay5;
  logic signed [2*GRAD_BITS-1:0] sqx_full, sqy_full;
  logic [SQ_BITS-2:0]            sqx5, sqy5;
  logic                          brd5;

  // threshold stage
  logic [EDGE_BITS-1:0]        e1_6, e3_6;
  logic [MAG_BITS-1:0]         ax6;
  logic signed [GRAD_BITS-1:0] ay6;
  logic [SQ_BITS-1:0]          sq6;
  logic                        brd6;

  // bin stage
  logic signed [CMP_BITS-1:0] ays, e1s, e2s, e3s;
  logic [6:0]                 ge;
  bin_t                       bin_raw;
  bin_t                       bin_next;
  sqrt_in_t                   sq_in_next;
  sqrt_in_t                   sq_in;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_spread <= INV_SPREAD_RESET;
    end else if (cfg_wr_en) begin
      inv_spread <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_LAT-2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    brd_d <= {brd_d[SCALE_LAT-2:0], pixels.on_border};
  end

  gob_scale u_scale_y (
    .clk        (clk),
    .inv_spread (inv_spread),
    .hi         (pixels.pixel_below),
    .lo         (pixels.pixel_above),
    .mag        (mag_y),
    .neg        (neg_y)
  );

  gob_scale u_scale_x (
    .clk        (clk),
    .inv_spread (inv_spread),
    .hi         (pixels.pixel_right),
    .lo         (pixels.pixel_left),
    .mag        (mag_x),
    .neg        (neg_x)
  );

  // signed gradient, bias on dx with saturation at the positive end only
  assign dx_wide = (neg_x ? -$signed({2'b00, mag_x}) : $signed({2'b00, mag_x}))
                   + (GRAD_BITS+1)'(DX_BIAS);

  always_ff @(posedge clk) begin
    dx4  <= (dx_wide > $signed((GRAD_BITS+1)'(GRAD_MAX))) ? $signed(GRAD_BITS'(GRAD_MAX))
                                                         : dx_wide[GRAD_BITS-1:0];
    dy4  <= neg_y ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
    brd4 <= brd_d[SCALE_LAT-1];
  end

  // fold into the right half plane; squares taken from the unfolded values
  assign sqx_full = (2*GRAD_BITS)'(dx4) * (2*GRAD_BITS)'(dx4);
  assign sqy_full = (2*GRAD_BITS)'(dy4) * (2*GRAD_BITS)'(dy4);

  always_ff @(posedge clk) begin
    ax5  <= dx4[GRAD_BITS-1] ? MAG_BITS'(-dx4) : dx4[MAG_BITS-1:0];
    ay5  <= dx4[GRAD_BITS-1] ? -dy4 : dy4;
    sqx5 <= sqx_full[SQ_BITS-2:0];
    sqy5 <= sqy_full[SQ_BITS-2:0];
    brd5 <= brd4;
  end

  always_ff @(posedge clk) begin
    e1_6 <= EDGE_BITS'(TAN22_Q30) * EDGE_BITS'(ax5);
    e3_6 <= EDGE_BITS'(TAN67_Q30) * EDGE_BITS'(ax5);
    ax6  <= ax5;
    ay6  <= ay5;
    sq6  <= SQ_BITS'(sqx5) + SQ_BITS'(sqy5);
    brd6 <= brd5;
  end

  // ay against seven sector edges, all scaled by 2^30
  always_comb begin
    ays = $signed({{(CMP_BITS-GRAD_BITS-TAN_FRAC){ay6[GRAD_BITS-1]}}, ay6,
                   {TAN_FRAC{1'b0}}});
    e1s = $signed(CMP_BITS'(e1_6));
    e2s = $signed(CMP_BITS'({ax6, {TAN_FRAC{1'b0}}}));
    e3s = $signed(CMP_BITS'(e3_6));
    ge[0] = ays >= -e3s;
    ge[1] = ays >= -e2s;
    ge[2] = ays >= -e1s;
    ge[3] = ays >= $signed(CMP_BITS'(0));
    ge[4] = ays >= e1s;
    ge[5] = ays >= e2s;
    ge[6] = ays >= e3s;
    bin_raw = BIN_BITS'($countones(ge)) + BIN_OFFSET;

    if (brd6) begin
      bin_next = BIN_BORDER;
    end else if (ax6 == '0 && !ay6[GRAD_BITS-1] && ay6 != '0) begin
      bin_next = BIN_VERTICAL;
    end else begin
      bin_next = bin_raw;
    end

    sq_in_next.bin      = bin_next;
    sq_in_next.radicand = brd6 ? '0 : RAD_BITS'(sq6);
  end

  always_ff @(posedge clk) begin
    sq_in <= sq_in_next;
  end

  gob_isqrt u_isqrt (
    .clk    (clk),
    .sq_in  (sq_in),
    .sq_out (result)
  );

  assign result_valid = vld[PIPE_LAT-1];

endmodule

@@ rtl/gob_scale.sv @@
// three-stage pipeline: absolute central difference times inverse spread,
// truncated and saturated to the gradient format; depends on gob_pkg
`timescale 1ns / 1ps

module gob_scale import gob_pkg::*; (
  input  logic                   clk,
  input  logic [SPREAD_BITS-1:0] inv_spread,
  input  logic [PIXEL_BITS-1:0]  hi,
  input  logic [PIXEL_BITS-1:0]  lo,
  output logic [MAG_BITS-1:0]    mag,
  output logic                   neg
);

  logic [PIXEL_BITS-1:0]   diff1;
  logic                    neg1;
  logic [PROD_HI_BITS-1:0] prod_hi2;
  logic [PROD_LO_BITS-1:0] prod_lo2;
  logic                    neg2;
  logic [SUM_BITS-1:0]     sum;

  always_ff @(posedge clk) begin
    neg1  <= lo > hi;
    diff1 <= (lo > hi) ? lo - hi : hi - lo;
  end

  // split product keeps each multiplier within 32 bits
  always_ff @(posedge clk) begin
    prod_hi2 <= PROD_HI_BITS'(diff1) * PROD_HI_BITS'(inv_spread[SPREAD_BITS-1:SCALE_SHIFT]);
    prod_lo2 <= PROD_LO_BITS'(diff1) * PROD_LO_BITS'(inv_spread[SCALE_SHIFT-1:0]);
    neg2     <= neg1;
  end

  assign sum = SUM_BITS'(prod_hi2) + SUM_BITS'(prod_lo2[PROD_LO_BITS-1:SCALE_SHIFT]);

  always_ff @(posedge clk) begin
    mag <= (sum > SUM_BITS'(GRAD_MAX)) ? GRAD_MAX : sum[MAG_BITS-1:0];
    neg <= neg2;
  end

endmodule

@@ rtl/gob_isqrt.sv @@
// pipelined integer square root, one result bit per stage, with the bin
// carried alongside; depends on gob_pkg
`timescale 1ns / 1ps

module gob_isqrt import gob_pkg::*; (
  input  logic         clk,
  input  sqrt_in_t     sq_in,
  output result_item_t sq_out
);

  logic [RAD_BITS-1:0]  rad_s  [SQRT_STAGES+1];
  logic [REM_BITS-1:0]  rem_s  [SQRT_STAGES+1];
  logic [ROOT_BITS-1:0] root_s [SQRT_STAGES+1];
  bin_t                 bin_s  [SQRT_STAGES+1];

  assign rad_s[0]  = sq_in.radicand;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign bin_s[0]  = sq_in.bin;

  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
    logic [REM_BITS-1:0] rem_sh;
    logic [REM_BITS-1:0] trial;
    logic                ge;

    always_comb begin
      rem_sh = {rem_s[i][REM_BITS-3:0], rad_s[i][RAD_BITS-1 -: 2]};
      trial  = REM_BITS'({root_s[i], 2'b01});
      ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      rad_s[i+1]  <= {rad_s[i][RAD_BITS-3:0], 2'b00};
      rem_s[i+1]  <= ge ? rem_sh - trial : rem_sh;
      root_s[i+1] <= {root_s[i][ROOT_BITS-2:0], ge};
      bin_s[i+1]  <= bin_s[i];
    end
  end

  assign sq_out.orientation_bin    = bin_s[SQRT_STAGES];
  assign sq_out.gradient_magnitude = root_s[SQRT_STAGES];

endmodule

@@ dv/tb_gradient_orientation_binner.sv @@
// testbench for gradient_orientation_binner, depends on gob_pkg: directed table then
// random pixel items, checked against tabled results or a gradient and bin predictor
`timescale 1ns / 1ps

module tb_gradient_orientation_binner;
  import gob_pkg::*;

  localparam int          DIFF_SHIFT   = 4 + 32 - 16;
  localparam longint      GRAD_SAT     = 64'sd2147483647;
  localparam longint      DX_OFFSET    = 64'sd7;
  localparam longint      TAN_LOW_Q30  = 64'sd444758426;
  localparam longint      TAN_HIGH_Q30 = 64'sd2592242074;
  localparam logic [SPREAD_BITS-1:0] SPREAD_ONE  = 40'h01_0000_0000;
  // one gradient lsb per pixel lsb, so small differences land exactly
  localparam logic [SPREAD_BITS-1:0] SPREAD_UNIT = 40'h00_0010_0000;
  localparam logic [SPREAD_BITS-1:0] SPREAD_ZERO = '0;
  localparam logic [SPREAD_BITS-1:0] SPREAD_TOP  = '1;
  localparam logic [PIXEL_BITS-1:0]  PIX_TOP     = '1;
  localparam bin_t        BIN_FLAT     = 3'd0;
  localparam int          CYCLE_LIMIT  = 20000;
  localparam int          DRAIN_CYCLES = 48;
  localparam int          PHASE_ITEMS  = 75;

  typedef struct {
    logic [SPREAD_BITS-1:0] spread;
    pixel_item_t            px;
    bit                     known;
    result_item_t           res;
  } stim_row_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  pixel_item_t            pixels;
  logic                   cfg_wr_en;
  logic [SPREAD_BITS-1:0] cfg_wr_data;
  logic                   result_valid;
  result_item_t           result;

  result_item_t           pending_results [$];
  logic [SPREAD_BITS-1:0] spread_now = SPREAD_ONE;
  int                     mismatches = 0;
  int                     cycles = 0;

  stim_row_t directed_rows [24] = '{
    '{SPREAD_ONE, '{24'd0, 24'd0, 24'd0, 24'd0, 1'b0}, 1'b1, '{BIN_FLAT, 32'd7}},
    '{SPREAD_ONE, '{PIX_TOP, PIX_TOP, PIX_TOP, PIX_TOP, 1'b0}, 1'b1, '{BIN_FLAT, 32'd7}},
    '{SPREAD_ONE, '{PIX_TOP, PIX_TOP, PIX_TOP, PIX_TOP, 1'b1}, 1'b1, '{BIN_BORDER, 32'd0}},
    '{SPREAD_ONE, '{24'd0, PIX_TOP, 24'd0, PIX_TOP, 1'b1}, 1'b1, '{BIN_BORDER, 32'd0}},
    '{SPREAD_ONE, '{24'd0, PIX_TOP, 24'd0, PIX_TOP, 1'b0}, 1'b0, '{BIN_FLAT, 32'd0}},
    '{SPREAD_ONE, '{PIX_TOP, 24'd0, PIX_TOP, 24'd0, 1'b0}, 1'b0, '{BIN_FLAT, 32'd0}},
    '{SPREAD_ONE, '{24'd0, PIX_TOP, PIX_TOP, 24'd0, 1'b0}, 1'b0, '{BIN_FLAT, 32'd0}},
    '{SPREAD_ONE, '{PIX_TOP, 24'd0, 24'd0, PIX_TOP, 1'b0}, 1'b0, '{BIN_FLAT, 32'd0}},
    '{SPREAD_ONE, '{24'd100, 24'd116, 24'd100, 24'd100, 1'b0}, 1'b0, '{BIN_FLAT, 32'd0}},
    // dx cancels the bias exactly, dy positive
    '{SPREAD_UNIT, '{24'd105, 24'd110, 24'd107, 24'd100, 1'b0}, 1'b1, '{BIN_VERTICAL, 32'd5}},
    '{SPREAD_UNIT, '{24'd110, 24'd105, 24'd107, 24'd100, 1'b0}, 1'b0, '{BIN_FLAT, 32'd0}},
    '{SPREAD_UNIT, '{24'd100, 24'd100, 24'd107, 24'd100, 1'b0}, 1'b0, '{BIN_FLAT, 32'd0}},
    '{SPREAD_UNIT, '{24'd200, 24'd220, 24'd300, 24'd313, 1'b0}, 1'b0, '{BIN_FLAT, 32'd0}},
    '{SPREAD_UNIT, '{24'd220, 24'd200, 24'd300, 24'd313, 1'b0}, 1'b0, '{BIN_FLAT, 32'd0}},
    '{SPREAD_UNIT, '{24'd1000, 24'd1043, 24'd50, 24'd0, 1'b0}, 1'b0, '{BIN_FLAT, 32'd0}},
    // either side of the tan 22.5 edge, and just under the tan 67.5 edge
    '{SPREAD_UNIT, '{24'd5000, 24'd5417, 24'd2000, 24'd3000, 1'b0}, 1'b0, '{BIN_FLAT, 32'd0}},
    '{SPREAD_UNIT, '{24'd5000, 24'd5418, 24'd2000, 24'd3000, 1'b0}, 1'b0, '{BIN_FLAT, 32'd0}},
    '{SPREAD_UNIT, '{24'd0, 24'd2431, 24'd0, 24'd1000, 1'b0}, 1'b0, '{BIN_FLAT, 32'd0}},
    '{SPREAD_ZERO, '{24'd0, PIX_TOP, 24'd0, PIX_TOP, 1'b0}, 1'b1, '{BIN_FLAT, 32'd7}},
    '{SPREAD_ZERO, '{PIX_TOP, 24'd0, PIX_TOP, 24'd0, 1'b1}, 1'b1, '{BIN_BORDER, 32'd0}},
    '{SPREAD_TOP, '{24'd0, PIX_TOP, 24'd0, PIX_TOP, 1'b0}, 1'b0, '{BIN_FLAT, 32'd0}},
    '{SPREAD_TOP, '{PIX_TOP, 24'd0, PIX_TOP, 24'd0, 1'b0}, 1'b0, '{BIN_FLAT, 32'd0}},
    '{SPREAD_TOP, '{24'd5, 24'd6, 24'd9, 24'd8, 1'b0}, 1'b0, '{BIN_FLAT, 32'd0}},
    '{SPREAD_TOP, '{PIX_TOP, 24'd0, 24'd0, PIX_TOP, 1'b1}, 1'b1, '{BIN_BORDER, 32'd0}}
  };

  gradient_orientation_binner dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .pixels       (pixels),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .result_valid (result_valid),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // signed difference times spread, truncated toward zero and clamped
  function automatic longint scale_diff(logic [PIXEL_BITS-1:0] hi, logic [PIXEL_BITS-1:0] lo,
                                        logic [SPREAD_BITS-1:0] spread);
    logic [63:0] span;
    logic [63:0] prod;
    span = (hi >= lo) ? 64'(hi - lo) : 64'(lo - hi);
    prod = (span * 64'(spread)) >> DIFF_SHIFT;
    if (prod > 64'(GRAD_SAT)) prod = 64'(GRAD_SAT);
    return (lo > hi) ? -longint'(prod) : longint'(prod);
  endfunction

  function automatic result_item_t predict_gradient(pixel_item_t p,
                                                    logic [SPREAD_BITS-1:0] spread);
    result_item_t r;
    longint       gx, gy, ax, ay, ys, t1, t2, t3;
    logic [63:0]  sq, root, trial;
    int           k;
    r = '0;
    if (p.on_border) return r;
    gy = scale_diff(p.pixel_below, p.pixel_above, spread);
    gx = scale_diff(p.pixel_right, p.pixel_left, spread) + DX_OFFSET;
    if (gx > GRAD_SAT) gx = GRAD_SAT;
    // fold into the right half plane
    ax = (gx < 0) ? -gx : gx;
    ay = (gx < 0) ? -gy : gy;
    ys = ay * (64'sd1 <<< 30);
    t1 = TAN_LOW_Q30 * ax;
    t2 = ax * (64'sd1 <<< 30);
    t3 = TAN_HIGH_Q30 * ax;
    k = int'(ys >= -t3) + int'(ys >= -t2) + int'(ys >= -t1) + int'(ys >= 0) +
        int'(ys >= t1) + int'(ys >= t2) + int'(ys >= t3);
    r.orientation_bin = bin_t'(k + 4);
    if (ax == 0 && ay > 0) r.orientation_bin = BIN_VERTICAL;
    sq = 64'(gx * gx) + 64'(gy * gy);
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= sq) root = trial;
    end
    r.gradient_magnitude = root[31:0];
    return r;
  endfunction

  // places two pixels that differ by span, hi minus lo negative when neg is set
  function automatic void place_pair(int unsigned span, bit neg,
                                     output logic [PIXEL_BITS-1:0] hi,
                                     output logic [PIXEL_BITS-1:0] lo);
    int unsigned base;
    base = $urandom_range(0, int'(PIX_TOP) - span);
    hi = PIXEL_BITS'(neg ? base : base + span);
    lo = PIXEL_BITS'(neg ? base + span : base);
  endfunction

  function automatic pixel_item_t random_pixel();
    pixel_item_t p;
    int unsigned mode, xs, ys;
    mode = $urandom_range(0, 9);
    p.on_border = ($urandom_range(0, 9) == 0);
    xs = $urandom() & ((32'd1 << $urandom_range(0, 24)) - 1);
    ys = $urandom() & ((32'd1 << $urandom_range(0, 24)) - 1);
    // near-diagonal gradients, with and without the bias folded in
    if (mode == 1) ys = xs;
    if (mode == 2 && xs < int'(PIX_TOP) - 7) ys = xs + 7;
    place_pair(xs, 1'($urandom_range(0, 1)), p.pixel_right, p.pixel_left);
    place_pair(ys, 1'($urandom_range(0, 1)), p.pixel_below, p.pixel_above);
    if (mode == 0) begin
      p.pixel_above = PIXEL_BITS'($urandom());
      p.pixel_below = PIXEL_BITS'($urandom());
      p.pixel_left  = PIXEL_BITS'($urandom());
      p.pixel_right = PIXEL_BITS'($urandom());
      p.on_border   = 1'($urandom_range(0, 1));
    end
    return p;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    mismatches++;
  endtask

  task automatic send_pixel(pixel_item_t p, bit known, result_item_t typed);
    pixels <= p;
    start  <= 1'b1;
    do @(posedge clk); while (busy);
    pending_results.push_back(known ? typed : predict_gradient(p, spread_now));
  endtask

  task automatic maybe_idle(bit quiet);
    if (!quiet && $urandom_range(0, 99) < 8) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // register changes only with the pipeline empty
  task automatic load_spread(logic [SPREAD_BITS-1:0] v);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    spread_now = v;
  endtask

  always @(posedge clk) begin
    result_item_t want;
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, magnitude", 64'(result.gradient_magnitude),
                        64'd0);
      end else begin
        want = pending_results.pop_front();
        if (result.orientation_bin !== want.orientation_bin)
          report_mismatch("orientation_bin", 64'(result.orientation_bin),
                          64'(want.orientation_bin));
        if (result.gradient_magnitude !== want.gradient_magnitude)
          report_mismatch("gradient_magnitude", 64'(result.gradient_magnitude),
                          64'(want.gradient_magnitude));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [SPREAD_BITS-1:0] plan [6];
    int                     n;
    start       <= 1'b0;
    pixels      <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    rst         <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].spread != spread_now) load_spread(directed_rows[i].spread);
      maybe_idle(1'b0);
      send_pixel(directed_rows[i].px, directed_rows[i].known, directed_rows[i].res);
    end

    plan[0] = SPREAD_UNIT;
    plan[1] = SPREAD_ONE;
    plan[2] = {8'($urandom()), 32'($urandom())};
    plan[3] = SPREAD_BITS'($urandom_range(1, 1 << 24));
    plan[4] = SPREAD_TOP;
    plan[5] = SPREAD_BITS'($urandom_range(1 << 18, 1 << 22));
    n = 0;
    foreach (plan[p]) begin
      load_spread(plan[p]);
      repeat (PHASE_ITEMS) begin
        // back-to-back stretch, interrupted by the spread load at a phase change
        maybe_idle(n >= 150 && n < 260);
        send_pixel(random_pixel(), 1'b0, '0);
        n++;
      end
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/gob_pkg.sv
rtl/gob_scale.sv
rtl/gob_isqrt.sv
rtl/gradient_orientation_binner.sv
dv/tb_gradient_orientation_binner.sv
